>>> src/ctb_pkg.sv
// Package: token kinds, character codes, queue entry type and classification functions.
`timescale 1ns / 1ps

package ctb_pkg;

  typedef logic [5:0] kind_t;

  // Token kinds as seen on the result channel
  localparam kind_t KIND_EOF      = 6'd0;
  localparam kind_t KIND_IDENT    = 6'd1;
  localparam kind_t KIND_NUMBER   = 6'd2;
  localparam kind_t KIND_AUTO     = 6'd3;
  localparam kind_t KIND_RETURN   = 6'd4;
  localparam kind_t KIND_REGISTER = 6'd5;
  localparam kind_t KIND_IF       = 6'd6;
  localparam kind_t KIND_ELSE     = 6'd7;
  localparam kind_t KIND_WHILE    = 6'd8;
  localparam kind_t KIND_SEMI     = 6'd9;
  localparam kind_t KIND_LPAREN   = 6'd10;
  localparam kind_t KIND_RPAREN   = 6'd11;
  localparam kind_t KIND_LBRACK   = 6'd12;
  localparam kind_t KIND_RBRACK   = 6'd13;
  localparam kind_t KIND_LBRACE   = 6'd14;
  localparam kind_t KIND_RBRACE   = 6'd15;
  localparam kind_t KIND_AT       = 6'd16;
  localparam kind_t KIND_COMMA    = 6'd17;
  localparam kind_t KIND_PLUS     = 6'd18;
  localparam kind_t KIND_MINUS    = 6'd19;
  localparam kind_t KIND_SLASH    = 6'd20;
  localparam kind_t KIND_PERCENT  = 6'd21;
  localparam kind_t KIND_STAR     = 6'd22;
  localparam kind_t KIND_TILDE    = 6'd23;
  localparam kind_t KIND_BAR      = 6'd24;
  localparam kind_t KIND_CARET    = 6'd25;
  localparam kind_t KIND_AMP      = 6'd26;
  localparam kind_t KIND_ANDAND   = 6'd27;
  localparam kind_t KIND_EQEQ     = 6'd28;
  localparam kind_t KIND_GE       = 6'd29;
  localparam kind_t KIND_LE       = 6'd30;
  localparam kind_t KIND_BANG     = 6'd31;
  localparam kind_t KIND_GT       = 6'd32;
  localparam kind_t KIND_NE       = 6'd33;
  localparam kind_t KIND_OROR     = 6'd34;
  localparam kind_t KIND_LT       = 6'd35;
  localparam kind_t KIND_SHL      = 6'd36;
  localparam kind_t KIND_ASSIGN   = 6'd37;
  localparam kind_t KIND_SHR      = 6'd38;
  localparam kind_t KIND_ERROR    = 6'd39;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  // Keywords packed first byte most significant
  localparam logic [63:0] KW_AUTO     = 64'h0000_0000_6175_746F;
  localparam logic [63:0] KW_RETURN   = 64'h0000_7265_7475_726E;
  localparam logic [63:0] KW_REGISTER = 64'h7265_6769_7374_6572;
  localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6966;
  localparam logic [63:0] KW_ELSE     = 64'h0000_0000_656C_7365;
  localparam logic [63:0] KW_WHILE    = 64'h0000_0077_6869_6C65;

  // One queue entry: all tokens caused by one byte; a second token never carries payload
  typedef struct packed {
    kind_t       token_kind;
    logic [63:0] number_value;
    logic [31:0] word_start;
    logic [31:0] word_length;
    logic [31:0] token_line;
    logic        has2;
    kind_t       kind2;
  } ctb_entry_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Bytes that may open a two-character operator or a comment
  function automatic logic is_lead_op(input logic [7:0] c);
    return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
           c == CH_AMP || c == CH_BAR || c == CH_SLASH;
  endfunction

  // Single-character operators; eof doubles as "no match"
  function automatic kind_t single_op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:    k = KIND_PLUS;
      CH_MINUS:   k = KIND_MINUS;
      CH_SLASH:   k = KIND_SLASH;
      CH_PERCENT: k = KIND_PERCENT;
      CH_STAR:    k = KIND_STAR;
      CH_TILDE:   k = KIND_TILDE;
      CH_BAR:     k = KIND_BAR;
      CH_CARET:   k = KIND_CARET;
      CH_AMP:     k = KIND_AMP;
      CH_BANG:    k = KIND_BANG;
      CH_GT:      k = KIND_GT;
      CH_LT:      k = KIND_LT;
      CH_EQ:      k = KIND_ASSIGN;
      default:    k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Punctuation; eof doubles as "no match"
  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_AT:     k = KIND_AT;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Two-character operators; eof doubles as "no match"
  function automatic kind_t two_char_kind(input logic [7:0] p, input logic [7:0] c);
    kind_t k;
    k = KIND_EOF;
    if (p == CH_EQ && c == CH_EQ)        k = KIND_EQEQ;
    else if (p == CH_BANG && c == CH_EQ) k = KIND_NE;
    else if (p == CH_LT && c == CH_EQ)   k = KIND_LE;
    else if (p == CH_LT && c == CH_LT)   k = KIND_SHL;
    else if (p == CH_GT && c == CH_EQ)   k = KIND_GE;
    else if (p == CH_GT && c == CH_GT)   k = KIND_SHR;
    else if (p == CH_AMP && c == CH_AMP) k = KIND_ANDAND;
    else if (p == CH_BAR && c == CH_BAR) k = KIND_OROR;
    return k;
  endfunction

  // Keyword lookup; ident when nothing matches
  function automatic kind_t keyword_kind(input logic [63:0] kw);
    kind_t k;
    case (kw)
      KW_AUTO:     k = KIND_AUTO;
      KW_RETURN:   k = KIND_RETURN;
      KW_REGISTER: k = KIND_REGISTER;
      KW_IF:       k = KIND_IF;
      KW_ELSE:     k = KIND_ELSE;
      KW_WHILE:    k = KIND_WHILE;
      default:     k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

>>> src/ctb_if.sv
// Channel interfaces: source byte channel and token channel.
`timescale 1ns / 1ps

interface ctb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_marker;

  modport source (output valid, output in_byte, output end_marker, input ready);
  modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface ctb_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [63:0] number_value;
  logic [31:0] word_start;
  logic [31:0] word_length;
  logic [31:0] token_line;
  logic        last_of_run;

  modport source (output valid, output token_kind, output number_value, output word_start,
                  output word_length, output token_line, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input number_value, input word_start,
                  input word_length, input token_line, input last_of_run, output ready);
endinterface

>>> src/ctb_front.sv
// Front end: accepts source bytes, runs the scanner and queues the tokens each byte causes.
`timescale 1ns / 1ps

module ctb_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  ctb_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                push_valid,
  output ctb_pkg::ctb_entry_t push_entry
);
  import ctb_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_WORD     = 7'b0000010,
    PH_LONGWORD = 7'b0000100,
    PH_NUMBER   = 7'b0001000,
    PH_OPPEND   = 7'b0010000,
    PH_COMMENT  = 7'b0100000,
    PH_HALTED   = 7'b1000000
  } phase_t;

  localparam logic [3:0] KW_MAX_BYTES = 4'd8;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [63:0]            kw_r, kw_nxt;
  logic [3:0]             kw_cnt_r, kw_cnt_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]            line_r, line_nxt;

  logic                   accept;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] word_len;
  logic [31:0]            line_inc;
  logic [67:0]            acc_wide;
  kind_t                  kw_kind;
  kind_t                  two_kind;
  logic                   open_tok;
  kind_t                  fl_kind;
  logic [63:0]            fl_val;
  logic [31:0]            fl_start;
  logic [31:0]            fl_len;
  logic                   have_flush;
  logic                   have_new;
  kind_t                  new_kind;
  logic                   start_idle;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign c           = in_ch.in_byte;
  assign word_len    = pos_r - start_r;
  assign line_inc    = (line_r == 32'hFFFF_FFFF) ? line_r : line_r + 32'd1;
  assign kw_kind     = keyword_kind(kw_r);
  assign two_kind    = two_char_kind(pend_r, c);
  // acc * 10 + digit, carries above bit 63 mean saturation
  assign acc_wide    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 68'(c[3:0]);
  assign open_tok    = phase_r == PH_WORD || phase_r == PH_LONGWORD ||
                       phase_r == PH_NUMBER || phase_r == PH_OPPEND;

  // Token left open by the current phase
  always_comb begin
    fl_kind  = KIND_EOF;
    fl_val   = '0;
    fl_start = '0;
    fl_len   = '0;
    if (phase_r == PH_WORD || phase_r == PH_LONGWORD) begin
      if (phase_r == PH_WORD && kw_kind != KIND_IDENT) begin
        fl_kind = kw_kind;
      end else begin
        fl_kind  = KIND_IDENT;
        fl_start = 32'(start_r);
        fl_len   = 32'(word_len);
      end
    end else if (phase_r == PH_NUMBER) begin
      fl_kind = KIND_NUMBER;
      fl_val  = acc_r;
    end else if (phase_r == PH_OPPEND) begin
      fl_kind = single_op_kind(pend_r);
    end
  end

  // Scanner next state
  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    kw_nxt     = kw_r;
    kw_cnt_nxt = kw_cnt_r;
    acc_nxt    = acc_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    have_flush = 1'b0;
    have_new   = 1'b0;
    new_kind   = KIND_EOF;
    start_idle = 1'b0;

    if (accept) begin
      if (in_ch.end_marker) begin
        // flush and rewind; a halted scanner stays silent
        if (phase_r != PH_HALTED) begin
          have_flush = open_tok;
          have_new   = 1'b1;
          new_kind   = KIND_EOF;
        end
        phase_nxt  = PH_IDLE;
        pend_nxt   = '0;
        kw_nxt     = '0;
        kw_cnt_nxt = '0;
        acc_nxt    = '0;
        start_nxt  = '0;
        pos_nxt    = '0;
        line_nxt   = 32'd1;
      end else if (phase_r == PH_HALTED) begin
        phase_nxt = PH_HALTED;
      end else if (phase_r == PH_COMMENT) begin
        if (c == CH_NUL) begin
          have_new  = 1'b1;
          new_kind  = KIND_EOF;
          phase_nxt = PH_HALTED;
        end else if (c == CH_NL) begin
          line_nxt  = line_inc;
          phase_nxt = PH_IDLE;
        end
        pos_nxt = pos_r + 1'b1;
      end else begin
        start_idle = 1'b1;
        if (phase_r == PH_WORD || phase_r == PH_LONGWORD) begin
          if (is_alpha(c) || is_digit(c)) begin
            if (phase_r == PH_WORD && kw_cnt_r < KW_MAX_BYTES) begin
              kw_nxt     = {kw_r[55:0], c};
              kw_cnt_nxt = kw_cnt_r + 4'd1;
            end else begin
              phase_nxt = PH_LONGWORD;
            end
            pos_nxt    = pos_r + 1'b1;
            start_idle = 1'b0;
          end else begin
            have_flush = 1'b1;
          end
        end else if (phase_r == PH_NUMBER) begin
          if (is_digit(c)) begin
            acc_nxt    = (acc_wide[67:64] != 4'd0) ? '1 : acc_wide[63:0];
            pos_nxt    = pos_r + 1'b1;
            start_idle = 1'b0;
          end else begin
            have_flush = 1'b1;
          end
        end else if (phase_r == PH_OPPEND) begin
          if (pend_r == CH_SLASH && c == CH_SLASH) begin
            phase_nxt  = PH_COMMENT;
            pos_nxt    = pos_r + 1'b1;
            start_idle = 1'b0;
          end else if (two_kind != KIND_EOF) begin
            have_new   = 1'b1;
            new_kind   = two_kind;
            phase_nxt  = PH_IDLE;
            pos_nxt    = pos_r + 1'b1;
            start_idle = 1'b0;
          end else begin
            have_flush = 1'b1;
          end
        end

        // byte opens something new
        if (start_idle) begin
          phase_nxt = PH_IDLE;
          if (c == CH_NUL) begin
            have_new  = 1'b1;
            new_kind  = KIND_EOF;
            phase_nxt = PH_HALTED;
          end else if (is_space(c)) begin
            if (c == CH_NL) begin
              line_nxt = line_inc;
            end
          end else if (is_alpha(c)) begin
            phase_nxt  = PH_WORD;
            kw_nxt     = {56'd0, c};
            kw_cnt_nxt = 4'd1;
            start_nxt  = pos_r;
          end else if (is_digit(c)) begin
            phase_nxt = PH_NUMBER;
            acc_nxt   = 64'(c[3:0]);
          end else if (is_lead_op(c)) begin
            phase_nxt = PH_OPPEND;
            pend_nxt  = c;
          end else if (single_op_kind(c) != KIND_EOF) begin
            have_new = 1'b1;
            new_kind = single_op_kind(c);
          end else if (punct_kind(c) != KIND_EOF) begin
            have_new = 1'b1;
            new_kind = punct_kind(c);
          end else begin
            have_new  = 1'b1;
            new_kind  = KIND_ERROR;
            phase_nxt = PH_HALTED;
          end
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  // Queue request: flushed token first, then the byte's own token
  always_comb begin
    push_entry            = '0;
    push_entry.token_line = line_r;
    if (have_flush) begin
      push_entry.token_kind   = fl_kind;
      push_entry.number_value = fl_val;
      push_entry.word_start   = fl_start;
      push_entry.word_length  = fl_len;
      push_entry.has2         = have_new;
      push_entry.kind2        = new_kind;
    end else begin
      push_entry.token_kind = new_kind;
    end
  end

  assign push_valid = have_flush || have_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pend_r   <= '0;
      kw_r     <= '0;
      kw_cnt_r <= '0;
      acc_r    <= '0;
      start_r  <= '0;
      pos_r    <= '0;
      line_r   <= 32'd1;
    end else begin
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      kw_r     <= kw_nxt;
      kw_cnt_r <= kw_cnt_nxt;
      acc_r    <= acc_nxt;
      start_r  <= start_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
    end
  end

  // a halted scanner only wakes on the end marker, and then silently
  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_HALTED) |-> !push_valid)
    else $error("token queued while halted");

  // keyword buffer never holds more than eight bytes while in a word
  a_kw_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WORD) |-> (kw_cnt_r != 4'd0 && kw_cnt_r <= KW_MAX_BYTES))
    else $error("keyword byte count out of range");

endmodule

>>> src/ctb_queue.sv
// Short queue of token requests between the scanner and the output stage.
`timescale 1ns / 1ps

module ctb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  ctb_pkg::ctb_entry_t push_entry,
  input  logic                pop,
  output ctb_pkg::ctb_entry_t head_entry,
  output logic                empty,
  output logic                full
);
  import ctb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  ctb_entry_t       entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty      = count_r == '0;
  assign full       = count_r == CNT_W'(DEPTH);
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = entries_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  // scanner must never offer a request into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("request pushed into full queue");

endmodule

>>> src/ctb_back.sv
// Output stage: drains queued requests into the result register, one token per ready cycle.
`timescale 1ns / 1ps

module ctb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ctb_pkg::ctb_entry_t head_entry,
  input  logic                empty,
  output logic                pop,
  ctb_out_if.source           out_ch
);
  import ctb_pkg::*;

  logic        valid_r;
  logic        second_r, second_nxt;
  logic        load;
  kind_t       kind_r;
  logic [63:0] value_r;
  logic [31:0] start_r;
  logic [31:0] len_r;
  logic [31:0] line_r;
  logic        last_r;

  // load when the result register is free or being taken
  assign load = !empty && (!valid_r || out_ch.ready);
  assign pop  = load && (second_r || !head_entry.has2);

  always_comb begin
    second_nxt = second_r;
    if (load) begin
      second_nxt = !second_r && head_entry.has2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // payload: the second token of a request carries only kind and line
  always_ff @(posedge clk) begin
    if (load) begin
      line_r <= head_entry.token_line;
      if (second_r) begin
        kind_r  <= head_entry.kind2;
        value_r <= '0;
        start_r <= '0;
        len_r   <= '0;
        last_r  <= 1'b1;
      end else begin
        kind_r  <= head_entry.token_kind;
        value_r <= head_entry.number_value;
        start_r <= head_entry.word_start;
        len_r   <= head_entry.word_length;
        last_r  <= !head_entry.has2;
      end
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.token_kind   = kind_r;
  assign out_ch.number_value = value_r;
  assign out_ch.word_start   = start_r;
  assign out_ch.word_length  = len_r;
  assign out_ch.token_line   = line_r;
  assign out_ch.last_of_run  = last_r;

  // a token that is not last of its run always has its partner still queued
  a_pair_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r) |-> (second_r && !empty))
    else $error("first of pair shown without its partner queued");

endmodule

>>> src/c_like_byte_tokenizer.sv
// Top level: byte-stream tokenizer for a small C-like language.
`timescale 1ns / 1ps
//
// Source bytes enter on in_ch (valid/ready), one request per byte, with
// end_marker set to close the input. Tokens leave on out_ch (valid/ready),
// one per cycle unless out_ch stalls, last_of_run marking the final token of a byte.
// Identifiers report start offset and length, numbers their saturated value,
// every token the line on which it was recognised.
// Throughput: one byte per cycle while the queue has room; the scanner resolves
// each byte as it is accepted, with one byte of lookahead held in its state.
// A token is on out_ch once the queue write and then the result register load
// have followed the byte that completes it.
// A byte that closes one token and is itself a token yields two tokens, which
// the output register sends one after the other; the request queue of
// QUEUE_DEPTH entries soaks this up, and in_ch.ready drops only when it fills.
// When out_ch stalls the result register holds and the queue fills behind it.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the scanner to line 1, offset 0, between tokens.
module c_like_byte_tokenizer #(
  parameter int OFFSET_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  ctb_in_if.sink    in_ch,
  ctb_out_if.source out_ch
);
  import ctb_pkg::*;

  ctb_entry_t push_entry;
  ctb_entry_t head_entry;
  logic       push_valid;
  logic       pop;
  logic       q_empty;
  logic       q_full;

  ctb_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  ctb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  ctb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .empty      (q_empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> sim/ctb_token_checker.sv
// Token checker: predicts the token stream from accepted source bytes and compares the results.
`timescale 1ns / 1ps

module ctb_token_checker (
  input  logic clk,
  input  logic rst_n,
  ctb_in_if    in_mon,
  ctb_out_if   out_mon,
  output int   mismatch_count,
  output int   tokens_waiting,
  output int   tokens_checked
);
  import ctb_pkg::*;

  typedef enum logic [6:0] {
    SCAN_IDLE    = 7'b0000001,
    SCAN_WORD    = 7'b0000010,
    SCAN_LONG    = 7'b0000100,
    SCAN_NUMBER  = 7'b0001000,
    SCAN_OP      = 7'b0010000,
    SCAN_COMMENT = 7'b0100000,
    SCAN_HALTED  = 7'b1000000
  } scan_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] line;
    logic        last;
  } token_t;

  // Scanner copy
  scan_t       phase;
  logic [7:0]  held_op;
  logic [63:0] kw_bytes;
  logic [63:0] num_acc;
  logic [31:0] word_begin;
  logic [31:0] offset;
  logic [31:0] line_no;

  // Tokens still to arrive, oldest first
  token_t token_backlog[$];
  token_t held;
  logic   held_ok = 1'b0;
  int     bad_count = 0;
  int     seen_count = 0;

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Lone operators; eof means none
  function automatic kind_t lone_op(input logic [7:0] c);
    case (c)
      CH_PLUS:    return KIND_PLUS;
      CH_MINUS:   return KIND_MINUS;
      CH_SLASH:   return KIND_SLASH;
      CH_PERCENT: return KIND_PERCENT;
      CH_STAR:    return KIND_STAR;
      CH_TILDE:   return KIND_TILDE;
      CH_BAR:     return KIND_BAR;
      CH_CARET:   return KIND_CARET;
      CH_AMP:     return KIND_AMP;
      CH_BANG:    return KIND_BANG;
      CH_GT:      return KIND_GT;
      CH_LT:      return KIND_LT;
      CH_EQ:      return KIND_ASSIGN;
      default:    return KIND_EOF;
    endcase
  endfunction

  function automatic kind_t punct_of(input logic [7:0] c);
    case (c)
      CH_SEMI:   return KIND_SEMI;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_AT:     return KIND_AT;
      CH_COMMA:  return KIND_COMMA;
      default:   return KIND_EOF;
    endcase
  endfunction

  function automatic kind_t pair_op(input logic [7:0] p, input logic [7:0] c);
    if (p == CH_EQ && c == CH_EQ) return KIND_EQEQ;
    if (p == CH_BANG && c == CH_EQ) return KIND_NE;
    if (p == CH_LT && c == CH_EQ) return KIND_LE;
    if (p == CH_LT && c == CH_LT) return KIND_SHL;
    if (p == CH_GT && c == CH_EQ) return KIND_GE;
    if (p == CH_GT && c == CH_GT) return KIND_SHR;
    if (p == CH_AMP && c == CH_AMP) return KIND_ANDAND;
    if (p == CH_BAR && c == CH_BAR) return KIND_OROR;
    return KIND_EOF;
  endfunction

  function automatic kind_t keyword_of(input logic [63:0] kw);
    case (kw)
      KW_AUTO:     return KIND_AUTO;
      KW_RETURN:   return KIND_RETURN;
      KW_REGISTER: return KIND_REGISTER;
      KW_IF:       return KIND_IF;
      KW_ELSE:     return KIND_ELSE;
      KW_WHILE:    return KIND_WHILE;
      default:     return KIND_IDENT;
    endcase
  endfunction

  task automatic rewind();
    phase      = SCAN_IDLE;
    held_op    = '0;
    kw_bytes   = '0;
    num_acc    = '0;
    word_begin = '0;
    offset     = '0;
    line_no    = 32'd1;
  endtask

  task automatic bump_line();
    if (line_no != 32'hFFFF_FFFF) line_no = line_no + 32'd1;
  endtask

  // Held back one place so the final token of a byte can be flagged
  task automatic add_token(input kind_t k, input logic [63:0] v, input logic [31:0] s,
                           input logic [31:0] l);
    if (held_ok) token_backlog.push_back(held);
    held    = '{kind: k, value: v, start: s, length: l, line: line_no, last: 1'b0};
    held_ok = 1'b1;
  endtask

  // Emit whatever token is open; an open comment is simply dropped
  task automatic close_token();
    kind_t k;
    case (phase)
      SCAN_WORD, SCAN_LONG: begin
        k = (phase == SCAN_WORD) ? keyword_of(kw_bytes) : KIND_IDENT;
        if (k == KIND_IDENT) add_token(KIND_IDENT, '0, word_begin, offset - word_begin);
        else add_token(k, '0, '0, '0);
      end
      SCAN_NUMBER: add_token(KIND_NUMBER, num_acc, '0, '0);
      SCAN_OP:     add_token(lone_op(held_op), '0, '0, '0);
      default: ;
    endcase
    phase = SCAN_IDLE;
  endtask

  // One accepted source request: update the scanner, queue the tokens it yields
  task automatic tokenise_byte(input logic [7:0] c, input logic stop);
    kind_t       two;
    logic [63:0] digit;
    logic        taken;
    held_ok = 1'b0;
    taken   = 1'b0;
    if (stop) begin
      if (phase != SCAN_HALTED) begin
        close_token();
        add_token(KIND_EOF, '0, '0, '0);
      end
      rewind();
    end else if (phase == SCAN_HALTED) begin
      // bytes after eof or error are dropped
    end else if (phase == SCAN_COMMENT) begin
      if (c == CH_NUL) begin
        add_token(KIND_EOF, '0, '0, '0);
        phase = SCAN_HALTED;
      end else if (c == CH_NL) begin
        bump_line();
        phase = SCAN_IDLE;
      end
      offset = offset + 32'd1;
    end else begin
      // continue the open token if the byte belongs to it
      case (phase)
        SCAN_WORD, SCAN_LONG: begin
          if (alpha_byte(c) || digit_byte(c)) begin
            if (phase == SCAN_WORD && (offset - word_begin) < 32'd8)
              kw_bytes = {kw_bytes[55:0], c};
            else
              phase = SCAN_LONG;
            taken = 1'b1;
          end else begin
            close_token();
          end
        end
        SCAN_NUMBER: begin
          if (digit_byte(c)) begin
            digit = {56'd0, c - CH_0};
            if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
              num_acc = 64'hFFFF_FFFF_FFFF_FFFF;
            else
              num_acc = num_acc * 64'd10 + digit;
            taken = 1'b1;
          end else begin
            close_token();
          end
        end
        SCAN_OP: begin
          two = pair_op(held_op, c);
          if (held_op == CH_SLASH && c == CH_SLASH) begin
            phase = SCAN_COMMENT;
            taken = 1'b1;
          end else if (two != KIND_EOF) begin
            add_token(two, '0, '0, '0);
            phase = SCAN_IDLE;
            taken = 1'b1;
          end else begin
            close_token();
          end
        end
        default: ;
      endcase
      // otherwise the byte starts something new
      if (!taken) begin
        if (c == CH_NUL) begin
          add_token(KIND_EOF, '0, '0, '0);
          phase = SCAN_HALTED;
        end else if (blank_byte(c)) begin
          if (c == CH_NL) bump_line();
        end else if (alpha_byte(c)) begin
          phase      = SCAN_WORD;
          kw_bytes   = {56'd0, c};
          word_begin = offset;
        end else if (digit_byte(c)) begin
          phase   = SCAN_NUMBER;
          num_acc = {56'd0, c - CH_0};
        end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
                     c == CH_AMP || c == CH_BAR || c == CH_SLASH) begin
          phase   = SCAN_OP;
          held_op = c;
        end else if (lone_op(c) != KIND_EOF) begin
          add_token(lone_op(c), '0, '0, '0);
        end else if (punct_of(c) != KIND_EOF) begin
          add_token(punct_of(c), '0, '0, '0);
        end else begin
          add_token(KIND_ERROR, '0, '0, '0);
          phase = SCAN_HALTED;
        end
      end
      offset = offset + 32'd1;
    end
    if (held_ok) begin
      held.last = 1'b1;
      token_backlog.push_back(held);
      held_ok = 1'b0;
    end
  endtask

  // One accepted token: compare with the oldest one due
  task automatic check_token();
    token_t got;
    token_t want;
    got = '{kind: out_mon.token_kind, value: out_mon.number_value,
            start: out_mon.word_start, length: out_mon.word_length,
            line: out_mon.token_line, last: out_mon.last_of_run};
    seen_count++;
    if (token_backlog.size() == 0) begin
      if (bad_count < 10)
        $display("%0t: token %0d not due: kind %0d value %0d start %0d length %0d line %0d",
                 $realtime, seen_count, got.kind, got.value, got.start, got.length, got.line);
      bad_count++;
    end else begin
      want = token_backlog.pop_front();
      if (got.kind !== want.kind || got.value !== want.value || got.start !== want.start ||
          got.length !== want.length || got.line !== want.line || got.last !== want.last) begin
        if (bad_count < 10) begin
          $display("%0t: token %0d wrong", $realtime, seen_count);
          $display("  want kind %0d value %0d start %0d length %0d line %0d last %0d",
                   want.kind, want.value, want.start, want.length, want.line, want.last);
          $display("  got  kind %0d value %0d start %0d length %0d line %0d last %0d",
                   got.kind, got.value, got.start, got.length, got.line, got.last);
        end
        bad_count++;
      end
    end
  endtask

  // Watch both channels at each rising edge; source side first
  always @(posedge clk) begin
    if (!rst_n) begin
      rewind();
      token_backlog.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) tokenise_byte(in_mon.in_byte, in_mon.end_marker);
      if (out_mon.valid && out_mon.ready) check_token();
    end
    mismatch_count <= bad_count;
    tokens_waiting <= token_backlog.size();
    tokens_checked <= seen_count;
  end

endmodule

>>> sim/c_like_byte_tokenizer_test.sv
// Testbench top: source byte stimulus, token back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module c_like_byte_tokenizer_test;
  import ctb_pkg::*;

  localparam int SOURCE_ITEMS = 650;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF     = 300;

  typedef struct packed {
    logic       end_marker;
    logic [7:0] value;
  } source_req_t;

  logic clk;
  logic rst_n;

  ctb_in_if  in_ch();
  ctb_out_if out_ch();

  int mismatch_count;
  int tokens_waiting;
  int tokens_checked;

  source_req_t source_queue[$];
  int          end_count = 0;

  string      keyword_text[6] = '{"auto", "return", "register", "if", "else", "while"};
  string      pair_text[8]    = '{"==", "!=", "<=", "<<", ">=", ">>", "&&", "||"};
  string      lone_text       = "+-/%*~|^&!><=";
  string      punct_text      = ";()[]{}@,";
  logic [7:0] blank_char[6]   = '{CH_SPACE, CH_TAB, CH_NL, 8'h0B, 8'h0C, CH_CR};

  c_like_byte_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ctb_token_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .tokens_waiting (tokens_waiting),
    .tokens_checked (tokens_checked)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic put_byte(input logic [7:0] b);
    source_queue.push_back('{end_marker: 1'b0, value: b});
  endtask

  // the byte lane is don't-care with the end marker, so it gets noise
  task automatic put_end();
    source_queue.push_back('{end_marker: 1'b1, value: 8'($urandom_range(0, 255))});
    end_count++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char(input logic first);
    int r;
    r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return CH_LA + 8'(r);
    if (r < 52) return CH_UA + 8'(r - 26);
    if (r == 52) return CH_USCORE;
    return CH_0 + 8'(r - 53);
  endfunction

  // Watchdog: too long without any accepted transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Token side: random stalls, calm stretches and two long hold-offs
  initial begin : receiver
    int got;
    int wait_n;
    got          = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (got == 60 || got == 250) wait_n = HOLD_OFF;
      else if ((got / 40) % 3 == 1) wait_n = 0;
      else wait_n = $urandom_range(0, 7);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int         gap;
    int         len;
    int         frags;
    int         ignored;
    logic [7:0] b;

    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.end_marker = 1'b0;
    rst_n            = 1'b0;
    ignored          = 0;

    // Directed: end marker on empty input, lone slash as division,
    // operator left pending at the end, invalid top byte then halted bytes,
    // zero byte inside a comment, invalid dot after an open word, bare number
    put_end();
    put_text("x/y\n");
    put_text("<");
    put_end();
    put_byte(8'hFF);
    put_byte(CH_LA);
    put_end();
    put_text("//c");
    put_byte(CH_NUL);
    put_byte(CH_UA);
    put_end();
    put_text("ab.");
    put_end();
    put_text("9");
    put_end();

    // Random: short programs of well-formed tokens, now and then broken by noise
    while (source_queue.size() - ignored < SOURCE_ITEMS) begin
      frags = $urandom_range(3, 15);
      for (int f = 0; f < frags; f++) begin
        case ($urandom_range(0, 8))
          0, 1, 2: begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            put_byte(rand_word_char(1'b1));
            for (int k = 1; k < len; k++) put_byte(rand_word_char(1'b0));
          end
          3: begin
            put_text(keyword_text[$urandom_range(0, 5)]);
            if ($urandom_range(0, 3) == 0) put_byte(rand_word_char(1'b0));
          end
          4: begin
            repeat ($urandom_range(1, 5)) put_byte(CH_0 + 8'($urandom_range(0, 9)));
          end
          5: begin
            // around the saturation point
            case ($urandom_range(0, 3))
              0: put_text("18446744073709551615");
              1: put_text("18446744073709551616");
              2: put_text("1844674407370955161");
              default: repeat ($urandom_range(20, 26))
                put_byte(CH_0 + 8'($urandom_range(0, 9)));
            endcase
          end
          6: put_byte(punct_text[$urandom_range(0, punct_text.len() - 1)]);
          7: put_byte(lone_text[$urandom_range(0, lone_text.len() - 1)]);
          default: put_text(pair_text[$urandom_range(0, 7)]);
        endcase

        // separator: none, whitespace or a line comment
        case ($urandom_range(0, 7))
          0, 1, 2: ;
          3, 4: put_byte(CH_SPACE);
          5: put_byte(blank_char[$urandom_range(0, 5)]);
          6: put_byte(CH_NL);
          default: begin
            put_text("//");
            repeat ($urandom_range(0, 6)) begin
              b = 8'($urandom_range(1, 255));
              if (b == CH_NL) b = CH_SPACE;
              put_byte(b);
            end
            put_byte(CH_NL);
          end
        endcase

        // noise: any byte, zero now and then, and what follows it is mostly dropped
        if ($urandom_range(0, 59) == 0) begin
          put_byte(($urandom_range(0, 2) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 3)) begin
            put_byte(8'($urandom_range(0, 255)));
            ignored++;
          end
          break;
        end
      end
      put_end();
    end

    // Reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Source side: random gaps with calm stretches
    @(negedge clk);
    for (int i = 0; i < source_queue.size(); i++) begin
      gap = ((i / 50) % 4 == 1) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid      <= 1'b1;
      in_ch.in_byte    <= source_queue[i].value;
      in_ch.end_marker <= source_queue[i].end_marker;
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;

    // Drain
    while (tokens_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d source requests over %0d end-marked runs; %0d tokens compared.",
             source_queue.size(), end_count, tokens_checked);
    $display("Included keywords, long words, saturating numbers, comments, errors, stalls.");
    if (mismatch_count == 0 && tokens_waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/ctb_pkg.sv
src/ctb_if.sv
src/ctb_front.sv
src/ctb_queue.sv
src/ctb_back.sv
src/c_like_byte_tokenizer.sv
sim/ctb_token_checker.sv
sim/c_like_byte_tokenizer_test.sv
